FILE: hdl/vkp_pkg.sv
// Shared types and constants for the VPD keyword list parser.
`timescale 1ns / 1ps

package vkp_pkg;

    localparam int BYTE_W = 8;
    localparam int NAME_W = 16;
    localparam int LEN_W  = 16;

    localparam logic [NAME_W-1:0] END_KEYWORD_RST = 16'h5046;
    localparam logic [BYTE_W-1:0] LONG_PREFIX_RST = 8'h23;

    // Configuration register indexes
    localparam logic CFG_END_KEYWORD = 1'b0;
    localparam logic CFG_LONG_PREFIX = 1'b1;

    typedef enum logic [1:0] {
        ROLE_NAME    = 2'd0,
        ROLE_LENGTH  = 2'd1,
        ROLE_VALUE   = 2'd2,
        ROLE_IGNORED = 2'd3
    } role_t;

    typedef struct packed {
        logic [NAME_W-1:0] end_keyword;
        logic [BYTE_W-1:0] long_prefix;
    } cfg_t;

    typedef struct packed {
        logic              list_done;
        logic              value_end;
        logic [LEN_W-1:0]  value_offset;
        logic [BYTE_W-1:0] value_byte;
        logic [NAME_W-1:0] keyword_name;
        role_t             byte_role;
    } result_t;

endpackage

FILE: hdl/vkp_cfg.sv
// Configuration registers: terminator keyword and long-length prefix.
`timescale 1ns / 1ps

module vkp_cfg
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [vkp_pkg::NAME_W-1:0] cfg_wdata,
    output vkp_pkg::cfg_t             cfg
);

    logic [vkp_pkg::NAME_W-1:0] end_keyword_reg;
    logic [vkp_pkg::BYTE_W-1:0] long_prefix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_keyword_reg <= vkp_pkg::END_KEYWORD_RST;
            long_prefix_reg <= vkp_pkg::LONG_PREFIX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vkp_pkg::CFG_END_KEYWORD: end_keyword_reg <= cfg_wdata;
                vkp_pkg::CFG_LONG_PREFIX: long_prefix_reg <= cfg_wdata[vkp_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.end_keyword = end_keyword_reg;
    assign cfg.long_prefix = long_prefix_reg;

endmodule

FILE: hdl/vkp_fsm.sv
// Keyword list state machine: labels one byte per transfer.
`timescale 1ns / 1ps

module vkp_fsm
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  vkp_pkg::cfg_t              cfg,
    input  logic                       advance,
    input  logic [vkp_pkg::BYTE_W-1:0] data_byte,
    input  logic                       list_start,
    output vkp_pkg::result_t           result
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_NAME0 = 3'd1,
        PH_NAME1 = 3'd2,
        PH_LEN0  = 3'd3,
        PH_LEN1  = 3'd4,
        PH_VALUE = 3'd5
    } phase_t;

    phase_t                     phase_reg,  phase_next, phase_cur;
    logic [vkp_pkg::NAME_W-1:0] name_reg,   name_next;
    logic                       long_reg,   long_next;
    logic [vkp_pkg::LEN_W-1:0]  length_reg, length_next;
    logic [vkp_pkg::LEN_W-1:0]  count_reg,  count_next;
    logic [vkp_pkg::LEN_W-1:0]  count_inc;

    assign phase_cur = list_start ? PH_NAME0 : phase_reg;
    assign count_inc = count_reg + 16'd1;

    always_comb
    begin
        phase_next          = phase_cur;
        name_next           = name_reg;
        long_next           = long_reg;
        length_next         = length_reg;
        count_next          = count_reg;
        result.byte_role    = vkp_pkg::ROLE_IGNORED;
        result.keyword_name = '0;
        result.value_byte   = data_byte;
        result.value_offset = '0;
        result.value_end    = 1'b0;
        result.list_done    = 1'b0;

        unique case (phase_cur)
            PH_NAME0:
            begin
                name_next           = {data_byte, 8'h00};
                result.byte_role    = vkp_pkg::ROLE_NAME;
                result.keyword_name = name_next;
                phase_next          = PH_NAME1;
            end
            PH_NAME1:
            begin
                name_next           = {name_reg[15:8], data_byte};
                result.byte_role    = vkp_pkg::ROLE_NAME;
                result.keyword_name = name_next;
                // terminator check takes priority over the long-length prefix
                if (name_next == cfg.end_keyword)
                begin
                    result.list_done = 1'b1;
                    phase_next       = PH_IDLE;
                end
                else
                begin
                    long_next   = (name_reg[15:8] == cfg.long_prefix);
                    length_next = '0;
                    phase_next  = PH_LEN0;
                end
            end
            PH_LEN0:
            begin
                result.byte_role    = vkp_pkg::ROLE_LENGTH;
                result.keyword_name = name_reg;
                length_next         = {8'h00, data_byte};
                if (long_reg)
                    phase_next = PH_LEN1;
                else if (length_next == '0)
                begin
                    result.value_end = 1'b1;
                    phase_next       = PH_NAME0;
                end
                else
                begin
                    count_next = '0;
                    phase_next = PH_VALUE;
                end
            end
            PH_LEN1:
            begin
                result.byte_role    = vkp_pkg::ROLE_LENGTH;
                result.keyword_name = name_reg;
                length_next         = {data_byte, length_reg[7:0]};
                if (length_next == '0)
                begin
                    result.value_end = 1'b1;
                    phase_next       = PH_NAME0;
                end
                else
                begin
                    count_next = '0;
                    phase_next = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                result.byte_role    = vkp_pkg::ROLE_VALUE;
                result.keyword_name = name_reg;
                result.value_offset = count_reg;
                if (count_inc == length_reg)
                begin
                    result.value_end = 1'b1;
                    phase_next       = PH_NAME0;
                end
                else
                    count_next = count_inc;
            end
            default:
                phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            name_reg   <= '0;
            long_reg   <= 1'b0;
            length_reg <= '0;
            count_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            name_reg   <= name_next;
            long_reg   <= long_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/vkp_out.sv
// Result register with a skid stage towards the output stream.
`timescale 1ns / 1ps

module vkp_out
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  vkp_pkg::result_t push_data,
    output logic             push_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output vkp_pkg::result_t out_data
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    vkp_pkg::result_t main_reg;
    vkp_pkg::result_t skid_reg;
    logic             pop;
    logic             load_main;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign load_main  = push && (!main_valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            main_valid_reg <= 1'b1;
            if (!load_main)
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            // refill from the skid stage or drain
            main_valid_reg <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_main)
            main_reg <= push_data;
        else if (!push && pop && skid_valid_reg)
            main_reg <= skid_reg;
        if (push && !load_main)
            skid_reg <= push_data;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

FILE: hdl/vpd_keyword_tlv_parser.sv
// Top level of the VPD keyword list parser.
//
//   port group  dir  transfer holds
//   s_*         in   one raw list byte, list start flag
//   m_*         out  one labelled byte result per input byte
//   cfg_*       in   register write, no read-back
//
// One byte is accepted per cycle while s_tready is high; its result is
// registered. The only loop is the phase and counter update, a 16-bit
// increment and compare. A two-entry output stage (result plus skid) keeps
// s_tready high while one result is stalled; it drops only when both are
// full. Reset leaves the parser ignoring bytes until a list start.
`timescale 1ns / 1ps

module vpd_keyword_tlv_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] list_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] keyword_name, [23:16] value_byte, [39:24] value_offset
    output logic        m_tlast,   // value_end
    output logic [2:0]  m_tuser,   // [1:0] byte_role, [2] list_done
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    vkp_pkg::cfg_t    cfg;
    vkp_pkg::result_t result;
    vkp_pkg::result_t out_data;
    logic             accept;

    assign accept = s_tvalid && s_tready;

    vkp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vkp_fsm u_fsm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .advance    (accept),
        .data_byte  (s_tdata),
        .list_start (s_tuser[0]),
        .result     (result)
    );

    vkp_out u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (result),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = {out_data.value_offset, out_data.value_byte, out_data.keyword_name};
    assign m_tlast = out_data.value_end;
    assign m_tuser = {out_data.list_done, out_data.byte_role};

endmodule

FILE: test/vpd_keyword_tlv_parser_test.sv
// Self-checking testbench for the VPD keyword list parser: directed rows, then random lists.
`timescale 1ns / 1ps

module vpd_keyword_tlv_parser_test;

    typedef enum logic [2:0] {
        SEEK_IDLE,
        SEEK_NAME_HI,
        SEEK_NAME_LO,
        SEEK_LEN_LO,
        SEEK_LEN_HI,
        SEEK_VALUE
    } seek_t;

    typedef struct {
        logic [7:0]       data;
        logic             start;
        bit               typed;
        vkp_pkg::result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    // parser state as the testbench sees it
    seek_t       seek;
    logic [15:0] kw_name;
    logic [15:0] kw_len;
    logic [15:0] kw_count;
    logic        kw_long;
    logic [15:0] end_kw;
    logic [7:0]  long_prefix;

    vkp_pkg::result_t pending_labels[$];
    stim_row_t        dir_rows[$];
    int               mismatches = 0;
    int               parsed_count = 0;
    int               stall_left = 0;
    bit               idle_on = 1'b1;

    vpd_keyword_tlv_parser u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Once the length is complete: close a zero-length value or open the value.
    function automatic logic open_value();
        if (kw_len == 16'd0)
        begin
            seek = SEEK_NAME_HI;
            return 1'b1;
        end
        kw_count = 16'd0;
        seek = SEEK_VALUE;
        return 1'b0;
    endfunction

    function automatic string show(input vkp_pkg::result_t r);
        return $sformatf("role=%0d name=%h byte=%h off=%h end=%b done=%b", r.byte_role,
                         r.keyword_name, r.value_byte, r.value_offset, r.value_end,
                         r.list_done);
    endfunction

    function automatic vkp_pkg::result_t label_byte(input logic [7:0] b, input logic start);
        vkp_pkg::result_t r;
        r.byte_role    = vkp_pkg::ROLE_IGNORED;
        r.keyword_name = '0;
        r.value_byte   = b;
        r.value_offset = '0;
        r.value_end    = 1'b0;
        r.list_done    = 1'b0;
        if (start)
            seek = SEEK_NAME_HI;
        case (seek)
            SEEK_NAME_HI:
            begin
                kw_name = {b, 8'h00};
                r.byte_role = vkp_pkg::ROLE_NAME;
                r.keyword_name = kw_name;
                seek = SEEK_NAME_LO;
            end
            SEEK_NAME_LO:
            begin
                kw_name[7:0] = b;
                r.byte_role = vkp_pkg::ROLE_NAME;
                r.keyword_name = kw_name;
                // terminator wins over the long-length prefix
                if (kw_name == end_kw)
                begin
                    r.list_done = 1'b1;
                    seek = SEEK_IDLE;
                end
                else
                begin
                    kw_long = (kw_name[15:8] == long_prefix);
                    kw_len = 16'd0;
                    seek = SEEK_LEN_LO;
                end
            end
            SEEK_LEN_LO:
            begin
                kw_len = {8'h00, b};
                r.byte_role = vkp_pkg::ROLE_LENGTH;
                r.keyword_name = kw_name;
                if (kw_long)
                    seek = SEEK_LEN_HI;
                else
                    r.value_end = open_value();
            end
            SEEK_LEN_HI:
            begin
                kw_len[15:8] = b;
                r.byte_role = vkp_pkg::ROLE_LENGTH;
                r.keyword_name = kw_name;
                r.value_end = open_value();
            end
            SEEK_VALUE:
            begin
                r.byte_role = vkp_pkg::ROLE_VALUE;
                r.keyword_name = kw_name;
                r.value_offset = kw_count;
                if (kw_count + 16'd1 == kw_len)
                begin
                    r.value_end = 1'b1;
                    seek = SEEK_NAME_HI;
                end
                else
                    kw_count = kw_count + 16'd1;
            end
            default:
                seek = SEEK_IDLE;
        endcase
        return r;
    endfunction

    // Check each result transfer against the oldest expected label.
    always @(posedge clk)
    begin
        vkp_pkg::result_t got;
        vkp_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.keyword_name = m_tdata[15:0];
            got.value_byte   = m_tdata[23:16];
            got.value_offset = m_tdata[39:24];
            got.value_end    = m_tlast;
            got.byte_role    = vkp_pkg::role_t'(m_tuser[1:0]);
            got.list_done    = m_tuser[2];
            if (pending_labels.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result %s", $time, show(got));
            end
            else
            begin
                want = pending_labels.pop_front();
                if (got.byte_role !== want.byte_role || got.keyword_name !== want.keyword_name ||
                    got.value_byte !== want.value_byte ||
                    got.value_offset !== want.value_offset ||
                    got.value_end !== want.value_end || got.list_done !== want.list_done)
                begin
                    mismatches++;
                    $display("%0t: mismatch exp %s got %s", $time, show(want), show(got));
                end
            end
        end
    end

    // Receiver: stall in random bursts while idling is on.
    always @(negedge clk)
    begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 12);
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // Enter and leave at a falling edge; hold tvalid high between back-to-back bytes.
    task automatic send_byte(input logic [7:0] b, input logic start, input bit typed,
                             input vkp_pkg::result_t want);
        vkp_pkg::result_t r;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
        r = label_byte(b, start);
        pending_labels.insert(pending_labels.size(), typed ? want : r);
        if (r.byte_role != vkp_pkg::ROLE_IGNORED)
            parsed_count++;
        @(negedge clk);
    endtask

    task automatic row(input logic [7:0] b, input logic start, input bit typed,
                       input vkp_pkg::role_t role, input logic [15:0] name, input logic done);
        stim_row_t s;
        s.data  = b;
        s.start = start;
        s.typed = typed;
        s.want.byte_role    = role;
        s.want.keyword_name = name;
        s.want.value_byte   = b;
        s.want.value_offset = 16'd0;
        s.want.value_end    = 1'b0;
        s.want.list_done    = done;
        dir_rows.insert(dir_rows.size(), s);
    endtask

    // Wait for every expected result, then let the pipeline settle before a write.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_labels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] ekw, input logic [7:0] pfx);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= vkp_pkg::CFG_END_KEYWORD;
        cfg_wdata <= ekw;
        @(negedge clk);
        cfg_index <= vkp_pkg::CFG_LONG_PREFIX;
        cfg_wdata <= {8'($urandom), pfx};
        @(negedge clk);
        cfg_we <= 1'b0;
        end_kw = ekw;
        long_prefix = pfx;
    endtask

    // One keyword list: well-formed entries with random content, sometimes cut short.
    task automatic send_list();
        int          n_kw;
        int          len;
        int          cut;
        logic [15:0] nm;
        logic [7:0]  entry[$];
        bit          lng;
        n_kw = $urandom_range(1, 6);
        for (int k = 0; k <= n_kw; k++)
        begin
            case ($urandom_range(0, 5))
                0:       nm = {long_prefix, 8'($urandom)};
                1:       nm = {8'($urandom), 8'($urandom)};
                default: nm = {8'($urandom_range(8'h41, 8'h5A)),
                               8'($urandom_range(8'h30, 8'h5A))};
            endcase
            if (k == n_kw && $urandom_range(0, 3) != 0)
                nm = end_kw;
            lng = (nm[15:8] == long_prefix);
            case ($urandom_range(0, 7))
                0:       len = 0;
                1:       len = lng ? $urandom_range(0, 600) : $urandom_range(0, 255);
                default: len = $urandom_range(1, 6);
            endcase
            entry = {nm[15:8], nm[7:0]};
            if (nm != end_kw)
            begin
                entry.insert(entry.size(), 8'(len));
                if (lng)
                    entry.insert(entry.size(), 8'(len >> 8));
                repeat (len) entry.insert(entry.size(), 8'($urandom));
            end
            cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, entry.size() - 1)
                                               : entry.size();
            for (int i = 0; i < cut; i++)
                send_byte(entry[i], (k == 0 && i == 0), 1'b0, '0);
            if (cut < entry.size())
                return;
            if (nm == end_kw)
            begin
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0, 1'b0, '0);
                return;
            end
        end
    endtask

    task automatic random_part(input int target);
        parsed_count = 0;
        while (parsed_count < target)
        begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom), ($urandom_range(0, 7) == 0), 1'b0, '0);
            else
                send_list();
        end
    endtask

    initial
    begin
        logic [7:0] pfx;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = vkp_pkg::CFG_END_KEYWORD;
        cfg_wdata = 16'h0000;
        seek      = SEEK_IDLE;
        kw_name   = 16'h0000;
        kw_len    = 16'h0000;
        kw_count  = 16'h0000;
        kw_long   = 1'b0;
        end_kw      = vkp_pkg::END_KEYWORD_RST;
        long_prefix = vkp_pkg::LONG_PREFIX_RST;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ignored until a list start
        row(8'hFF, 1'b0, 1'b1, vkp_pkg::ROLE_IGNORED, 16'h0000, 1'b0);
        row(8'h00, 1'b0, 1'b1, vkp_pkg::ROLE_IGNORED, 16'h0000, 1'b0);
        row(8'h41, 1'b1, 1'b1, vkp_pkg::ROLE_NAME,    16'h4100, 1'b0);
        row(8'h42, 1'b0, 1'b1, vkp_pkg::ROLE_NAME,    16'h4142, 1'b0);
        row(8'h02, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        row(8'h00, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        row(8'hFF, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        // zero-length keyword: end flag on the length byte
        row(8'h5A, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        row(8'h5A, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        row(8'h00, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        // long length, one value byte
        row(8'h23, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        row(8'h31, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        row(8'h01, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        row(8'h00, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        row(8'hAA, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        // long length of zero
        row(8'h23, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        row(8'h58, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        row(8'h00, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        row(8'h00, 1'b0, 1'b0, vkp_pkg::ROLE_NAME,    16'h0000, 1'b0);
        // terminator, then an ignored byte
        row(8'h50, 1'b0, 1'b1, vkp_pkg::ROLE_NAME,    16'h5000, 1'b0);
        row(8'h46, 1'b0, 1'b1, vkp_pkg::ROLE_NAME,    16'h5046, 1'b1);
        row(8'h12, 1'b0, 1'b1, vkp_pkg::ROLE_IGNORED, 16'h0000, 1'b0);
        // restart after the terminator, then again after a complete name
        row(8'h50, 1'b1, 1'b1, vkp_pkg::ROLE_NAME,    16'h5000, 1'b0);
        row(8'h50, 1'b0, 1'b1, vkp_pkg::ROLE_NAME,    16'h5050, 1'b0);
        row(8'h7F, 1'b1, 1'b1, vkp_pkg::ROLE_NAME,    16'h7F00, 1'b0);
        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].typed, dir_rows[i].want);

        random_part(200);
        set_config(16'h0000, 8'h00);
        random_part(150);
        // terminator that starts with the long-length prefix
        set_config(16'hFFFF, 8'hFF);
        random_part(150);
        pfx = 8'($urandom);
        set_config({($urandom_range(0, 1) == 0) ? pfx : 8'($urandom), 8'($urandom)}, pfx);
        random_part(150);

        // last stretch without idling, including a value with a two-byte length
        idle_on = 1'b0;
        send_byte(long_prefix, 1'b1, 1'b0, '0);
        send_byte(~end_kw[7:0], 1'b0, 1'b0, '0);
        send_byte(8'h00, 1'b0, 1'b0, '0);
        send_byte(8'h01, 1'b0, 1'b0, '0);
        repeat (16'h0100) send_byte(8'($urandom), 1'b0, 1'b0, '0);
        random_part(100);

        drain();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hdl/vkp_pkg.sv
hdl/vkp_cfg.sv
hdl/vkp_fsm.sv
hdl/vkp_out.sv
hdl/vpd_keyword_tlv_parser.sv
test/vpd_keyword_tlv_parser_test.sv
